// ===== rtl/rctm_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the RTT trend monitor.
package rctm_pkg;

	localparam int RING_DEPTH = 16;
	localparam int PTR_W = $clog2(RING_DEPTH);
	localparam int CNT_W = $clog2(RING_DEPTH + 1);

	localparam int SAMPLE_W = 16;
	localparam int AVG_W = 32;
	localparam int RUN_W = 5;
	localparam int TREND_W = 2;
	localparam int RATIO_W = 10;
	localparam int OUT_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 10;

	localparam int TREND_MIN_SAMPLES = 10;

	// avg += (x - avg) / D by reciprocal multiply and one correction step
	localparam int SHORT_SHIFT = 37;
	localparam int LONG_SHIFT = 40;
	localparam logic [31:0] SHORT_DIV = 32'd60;
	localparam logic [31:0] LONG_DIV = 32'd300;
	localparam logic [31:0] SHORT_RECIP = 32'((64'd1 << SHORT_SHIFT) / 64'(SHORT_DIV));
	localparam logic [31:0] LONG_RECIP = 32'((64'd1 << LONG_SHIFT) / 64'(LONG_DIV));

	// floor(x / 10) for 16-bit x: (x * 52429) >> 19, exact over the full range
	localparam logic [31:0] TENTH_MUL = 32'd52429;
	localparam int TENTH_SHIFT = 19;

	localparam logic [TREND_W-1:0] TREND_STABLE = 2'd0;
	localparam logic [TREND_W-1:0] TREND_IMPROVING = 2'd1;
	localparam logic [TREND_W-1:0] TREND_DEGRADING = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMPROVE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEGRADE = 2'd2;

	localparam logic [4:0] TRIGGER_RESET = 5'd3;
	localparam logic [RATIO_W-1:0] IMPROVE_RESET = 10'd230;
	localparam logic [RATIO_W-1:0] DEGRADE_RESET = 10'd282;

	localparam logic [1:0] MUL_SHORT = 2'd0;
	localparam logic [1:0] MUL_LONG = 2'd1;
	localparam logic [1:0] MUL_IMP = 2'd2;
	localparam logic [1:0] MUL_DEG = 2'd3;

	typedef struct packed {
		logic accept;
		logic shift;
		logic walk_step;
		logic mul_en;
		logic [1:0] mul_sel;
		logic fix_short;
		logic fix_long;
		logic cap_imp;
		logic cap_trend;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic walk_done;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/rctm_ctrl.sv =====
// Sequencing state machine of the RTT trend monitor.
module rctm_ctrl import rctm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_axis_tvalid,
	output logic    s_axis_tready,
	input  status_t status,
	output cmd_t    cmd
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_PRIME0 = 4'd1;
	localparam logic [3:0] ST_PRIME1 = 4'd2;
	localparam logic [3:0] ST_WALK   = 4'd3;
	localparam logic [3:0] ST_S_MUL  = 4'd4;
	localparam logic [3:0] ST_S_FIX  = 4'd5;
	localparam logic [3:0] ST_L_MUL  = 4'd6;
	localparam logic [3:0] ST_L_FIX  = 4'd7;
	localparam logic [3:0] ST_R_IMP  = 4'd8;
	localparam logic [3:0] ST_R_DEG  = 4'd9;
	localparam logic [3:0] ST_R_CMP  = 4'd10;
	localparam logic [3:0] ST_FINISH = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign s_axis_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					cmd.accept = 1'b1;
					state_d = ST_PRIME0;
				end
			end
			ST_PRIME0: begin
				cmd.shift = 1'b1;
				state_d = ST_PRIME1;
			end
			ST_PRIME1: begin
				cmd.shift = 1'b1;
				state_d = ST_WALK;
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (status.walk_done) begin
					state_d = ST_S_MUL;
				end
			end
			ST_S_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_SHORT;
				state_d = ST_S_FIX;
			end
			ST_S_FIX: begin
				cmd.fix_short = 1'b1;
				state_d = ST_L_MUL;
			end
			ST_L_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_LONG;
				state_d = ST_L_FIX;
			end
			ST_L_FIX: begin
				cmd.fix_long = 1'b1;
				state_d = ST_R_IMP;
			end
			ST_R_IMP: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_IMP;
				state_d = ST_R_DEG;
			end
			ST_R_DEG: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_DEG;
				cmd.cap_imp = 1'b1;
				state_d = ST_R_CMP;
			end
			ST_R_CMP: begin
				cmd.cap_trend = 1'b1;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/rctm_datapath.sv =====
// Sample ring, averages, rising-run walk, ratio compare, config and output register.
module rctm_datapath import rctm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output status_t               status,
	input  logic [SAMPLE_W-1:0]   s_axis_tdata,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_W-1:0]      m_axis_tdata
);

	logic [4:0]          trigger_q;
	logic [RATIO_W-1:0]  improve_q;
	logic [RATIO_W-1:0]  degrade_q;

	logic [SAMPLE_W-1:0] ring [RING_DEPTH];
	logic [SAMPLE_W-1:0] rd_data_q;
	logic [SAMPLE_W-1:0] newer_q;
	logic [PTR_W-1:0]    wp_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    fill_q;
	logic [CNT_W-1:0]    fill_next;
	logic [CNT_W-1:0]    pairs_left_q;
	logic [RUN_W-1:0]    run_q;
	logic [4:0]          limit_q;
	logic [SAMPLE_W-1:0] x_q;

	logic [AVG_W-1:0]    short_q;
	logic [AVG_W-1:0]    long_q;
	logic                seeded_q;
	logic [AVG_W-1:0]    mag_q;
	logic                neg_q;
	logic [63:0]         prod_q;
	logic                imp_q;
	logic [TREND_W-1:0]  trend_q;

	logic                out_valid_q;
	logic [OUT_W-1:0]    out_data_q;

	// rising pair test on newer_q / rd_data_q (older)
	logic [31:0]         tenth_prod;
	logic [16:0]         threshold;
	logic                rising;
	logic                can_step;
	logic                hit_limit;

	always_comb begin
		tenth_prod = {16'b0, rd_data_q} * TENTH_MUL;
		threshold = {1'b0, rd_data_q} + 17'(tenth_prod >> TENTH_SHIFT);
		rising = (rd_data_q != '0) && ({1'b0, newer_q} > threshold);
		can_step = (pairs_left_q != '0) && rising;
		hit_limit = ({1'b0, run_q} + 6'd1) >= {1'b0, limit_q};
	end

	assign status.walk_done = (pairs_left_q == '0) || !rising || hit_limit;
	assign status.out_free = !out_valid_q || m_axis_tready;

	assign fill_next = (fill_q == CNT_W'(RING_DEPTH)) ? fill_q : fill_q + 1'b1;

	// average step and ratio products
	logic [AVG_W-1:0]    avg_mul;
	logic [AVG_W:0]      diff;
	logic                diff_neg;
	logic [AVG_W-1:0]    diff_mag;
	logic [31:0]         mul_a;
	logic [31:0]         mul_b;
	logic [63:0]         prod_w;

	always_comb begin
		avg_mul = (cmd.mul_sel == MUL_SHORT) ? short_q : long_q;
		diff = {1'b0, x_q, 16'b0} - {1'b0, avg_mul};
		diff_neg = diff[AVG_W];
		diff_mag = diff_neg ? AVG_W'(-diff) : diff[AVG_W-1:0];
		unique case (cmd.mul_sel)
			MUL_SHORT: begin
				mul_a = diff_mag;
				mul_b = SHORT_RECIP;
			end
			MUL_LONG: begin
				mul_a = diff_mag;
				mul_b = LONG_RECIP;
			end
			MUL_IMP: begin
				mul_a = long_q;
				mul_b = 32'(improve_q);
			end
			MUL_DEG: begin
				mul_a = long_q;
				mul_b = 32'(degrade_q);
			end
			default: begin
				mul_a = long_q;
				mul_b = '0;
			end
		endcase
		prod_w = {32'b0, mul_a} * {32'b0, mul_b};
	end

	logic [31:0]         quo_est;
	logic [31:0]         quo_back;
	logic [31:0]         quo_rem;
	logic [31:0]         quo_div;
	logic [31:0]         quo;
	logic [AVG_W-1:0]    avg_fix;
	logic [AVG_W-1:0]    avg_new;

	always_comb begin
		if (cmd.fix_long) begin
			quo_est = 32'(prod_q >> LONG_SHIFT);
			quo_back = quo_est * LONG_DIV;
			quo_div = LONG_DIV;
			avg_fix = long_q;
		end else begin
			quo_est = 32'(prod_q >> SHORT_SHIFT);
			quo_back = quo_est * SHORT_DIV;
			quo_div = SHORT_DIV;
			avg_fix = short_q;
		end
		quo_rem = mag_q - quo_back;
		quo = (quo_rem >= quo_div) ? quo_est + 32'd1 : quo_est;
		avg_new = neg_q ? avg_fix - quo : avg_fix + quo;
	end

	// ratio compare
	logic [63:0]         lhs;
	logic                trend_en;
	logic                congestion;

	always_comb begin
		lhs = {24'b0, short_q, 8'b0};
		trend_en = seeded_q && (32'(fill_q) >= 32'(TREND_MIN_SAMPLES)) && (long_q != '0);
		congestion = (run_q >= limit_q) && (32'(fill_q) >= 32'(limit_q));
	end

	// ring storage
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ring[wp_q] <= s_axis_tdata;
		end
		rd_data_q <= ring[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q <= s_axis_tdata;
		end
		if (cmd.shift || (cmd.walk_step && can_step)) begin
			newer_q <= rd_data_q;
		end
		if (cmd.mul_en) begin
			prod_q <= prod_w;
			mag_q <= diff_mag;
			neg_q <= diff_neg;
		end
		if (cmd.cap_imp) begin
			imp_q <= lhs < prod_q;
		end
		if (cmd.cap_trend) begin
			priority if (!trend_en) begin
				trend_q <= TREND_STABLE;
			end else if (imp_q) begin
				trend_q <= TREND_IMPROVING;
			end else if (lhs > prod_q) begin
				trend_q <= TREND_DEGRADING;
			end else begin
				trend_q <= TREND_STABLE;
			end
		end
		if (cmd.load_out) begin
			out_data_q <= {run_q, trend_q, congestion};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_q <= TRIGGER_RESET;
			improve_q <= IMPROVE_RESET;
			degrade_q <= DEGRADE_RESET;
			wp_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
			pairs_left_q <= '0;
			run_q <= '0;
			limit_q <= TRIGGER_RESET;
			short_q <= '0;
			long_q <= '0;
			seeded_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_TRIGGER: trigger_q <= cfg_data[4:0];
					CFG_IMPROVE: improve_q <= cfg_data;
					CFG_DEGRADE: degrade_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.accept) begin
				wp_q <= (wp_q == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
				rd_ptr_q <= wp_q;
				fill_q <= fill_next;
				pairs_left_q <= fill_next - 1'b1;
				run_q <= '0;
				limit_q <= (trigger_q == '0) ? 5'd1 : trigger_q;
				if (!seeded_q) begin
					short_q <= {s_axis_tdata, 16'b0};
					long_q <= {s_axis_tdata, 16'b0};
					seeded_q <= 1'b1;
				end
			end
			if (cmd.shift || (cmd.walk_step && can_step)) begin
				rd_ptr_q <= (rd_ptr_q == '0) ? PTR_W'(RING_DEPTH - 1) : rd_ptr_q - 1'b1;
			end
			if (cmd.walk_step && can_step) begin
				run_q <= run_q + 1'b1;
				pairs_left_q <= pairs_left_q - 1'b1;
			end
			if (cmd.fix_short) begin
				short_q <= avg_new;
			end
			if (cmd.fix_long) begin
				long_q <= avg_new;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	a_run_le_limit: assert property (@(posedge clk) disable iff (!arst_n)
		run_q <= limit_q)
		else $error("rising run passed the trigger limit");

	a_pairs_below_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(pairs_left_q < fill_q) || (fill_q == '0))
		else $error("walk would reach unwritten ring entries");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || m_axis_tready))
		else $error("pending result overwritten");

	a_congestion_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out && congestion |=> (m_axis_tdata[OUT_W-1:3] != '0))
		else $error("congestion flagged with empty run");

endmodule

// ===== rtl/rtt_congestion_trend_monitor.sv =====
// Top level of the RTT congestion and trend monitor: controller plus datapath.
//
// Each 16-bit RTT sample beat on s_axis yields one result beat on m_axis, and no new sample
// is taken until the item is done. An item walks backward over the sample ring, one step
// per rising pair counted, plus a stop step unless the run ends by reaching the trigger
// count; the two moving averages and the two ratio products then share one 32x32
// multiplier. A result waits in the output register while the next sample is taken;
// only a second result stalls behind it. Registers are written on the cfg port, which the
// user is to do only while the block is idle; the block itself does not enforce it:
// 0 trigger count, 1 improve ratio, 2 degrade ratio (2.8 fixed point).
module rtt_congestion_trend_monitor import rctm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // [15:0] rtt_sample
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_W-1:0]      m_axis_tdata,   // [0] congestion, [2:1] trend, [7:3] rising_run
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	rctm_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.status        (status),
		.cmd           (cmd)
	);

	rctm_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.s_axis_tdata  (s_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// ===== verif/tb_rtt_congestion_trend_monitor.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the RTT congestion and trend monitor: directed table, then random phases.
module tb_rtt_congestion_trend_monitor;
	import rctm_pkg::*;

	localparam int MAX_CYCLES = 1_000_000;
	localparam int ITEMS_PER_PHASE = 230;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 600;
	localparam int NUM_ROWS = 21;
	localparam int NUM_PHASES = 8;

	typedef struct packed {
		logic [RUN_W-1:0]   rising_run;
		logic [TREND_W-1:0] trend;
		logic               congestion;
	} rtt_report_t;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic [SAMPLE_W-1:0] sample;
		bit                  typed;
		rtt_report_t         want;
	} step_row_t;

	typedef struct {
		logic [4:0]         trigger;
		logic [RATIO_W-1:0] improve;
		logic [RATIO_W-1:0] degrade;
		idle_mode_t         idle;
		bit                 squeeze;
	} phase_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [SAMPLE_W-1:0]   s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_W-1:0]      m_axis_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_TRIGGER;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	rtt_congestion_trend_monitor u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shadow state of the monitor
	logic [SAMPLE_W-1:0] ring_copy [RING_DEPTH];
	logic [PTR_W-1:0]    wr_ptr;
	int                  fill;
	logic [AVG_W-1:0]    short_avg;
	logic [AVG_W-1:0]    long_avg;
	bit                  seeded;
	logic [4:0]          trig_cfg;
	logic [RATIO_W-1:0]  imp_cfg;
	logic [RATIO_W-1:0]  deg_cfg;

	rtt_report_t pending_reports [$];
	int          error_count = 0;
	int          cycle_count = 0;
	int          tx_idle_pct = 0;
	int          rx_stall_pct = 0;
	int          rx_hold_left = 0;
	int          last_sample = 0;
	int          ramp_left = 0;

	step_row_t directed_rows [NUM_ROWS];
	phase_t    plan [NUM_PHASES];

	function automatic logic [AVG_W-1:0] ema_update(logic [AVG_W-1:0] avg,
			logic [SAMPLE_W-1:0] x, longint divisor);
		longint base;
		longint diff;
		base = longint'({32'h0, avg});
		diff = longint'({16'h0, x, 16'h0}) - base;
		return AVG_W'(base + diff / divisor);
	endfunction

	function automatic rtt_report_t monitor_step(logic [SAMPLE_W-1:0] x);
		rtt_report_t      rep;
		int               limit;
		int               run;
		int               newer;
		int               older;
		logic [PTR_W-1:0] newer_idx;
		logic [PTR_W-1:0] older_idx;
		logic [63:0]      lhs;
		ring_copy[wr_ptr] = x;
		wr_ptr = wr_ptr + 1'b1;
		if (fill < RING_DEPTH)
			fill++;
		if (!seeded) begin
			short_avg = {x, 16'h0};
			long_avg = {x, 16'h0};
			seeded = 1'b1;
		end else begin
			short_avg = ema_update(short_avg, x, longint'(SHORT_DIV));
			long_avg = ema_update(long_avg, x, longint'(LONG_DIV));
		end
		limit = (trig_cfg == 0) ? 1 : int'(trig_cfg);
		run = 0;
		newer_idx = wr_ptr - 1'b1;
		for (int i = 0; i + 1 < fill; i++) begin
			older_idx = newer_idx - 1'b1;
			newer = int'(ring_copy[newer_idx]);
			older = int'(ring_copy[older_idx]);
			if (older == 0 || newer <= older + older / 10)
				break;
			run++;
			if (run >= limit)
				break;
			newer_idx = older_idx;
		end
		rep.congestion = (run >= limit && fill >= limit);
		rep.rising_run = RUN_W'(run);
		rep.trend = TREND_STABLE;
		if (fill >= TREND_MIN_SAMPLES && long_avg != 0) begin
			lhs = {24'h0, short_avg, 8'h0};
			if (lhs < 64'(imp_cfg) * 64'(long_avg))
				rep.trend = TREND_IMPROVING;
			else if (lhs > 64'(deg_cfg) * 64'(long_avg))
				rep.trend = TREND_DEGRADING;
		end
		return rep;
	endfunction

	// ramps of rising samples, wander, jumps, zeros and rise-threshold edges
	function automatic logic [SAMPLE_W-1:0] next_rtt();
		int x;
		int pick;
		pick = int'($urandom_range(99));
		if (ramp_left > 0) begin
			ramp_left--;
			x = last_sample + last_sample / 10 + 1 + int'($urandom_range(last_sample / 8 + 2));
			if (x > 65535)
				x = int'($urandom_range(1, 500));
		end else if (pick < 30) begin
			ramp_left = int'($urandom_range(2, 17));
			x = int'($urandom_range(1, 3000));
		end else if (pick < 55)
			x = last_sample - 50 + int'($urandom_range(100));
		else if (pick < 70)
			x = int'($urandom_range(65535));
		else if (pick < 76)
			x = 0;
		else if (pick < 88)
			x = int'($urandom_range(65535)) >> $urandom_range(8);
		else if (pick < 94)
			x = last_sample + last_sample / 10;
		else
			x = last_sample + last_sample / 10 + 1;
		if (x < 0)
			x = 0;
		if (x > 65535)
			x = 65535;
		last_sample = x;
		return SAMPLE_W'(x);
	endfunction

	task automatic compare_field(string field, int want, int got);
		if (want != got) begin
			error_count++;
			$display("%0t %s: expected %0d actual %0d", $time, field, want, got);
		end
	endtask

	task automatic check_report(logic [OUT_W-1:0] beat);
		rtt_report_t got;
		rtt_report_t want;
		got = beat;
		if (pending_reports.size() == 0) begin
			error_count++;
			$display("%0t unexpected beat: expected none actual %h", $time, beat);
			return;
		end
		want = pending_reports.pop_front();
		compare_field("congestion", want.congestion, got.congestion);
		compare_field("trend", want.trend, got.trend);
		compare_field("rising_run", want.rising_run, got.rising_run);
	endtask

	task automatic send_sample(logic [SAMPLE_W-1:0] x, bit typed, rtt_report_t want);
		rtt_report_t predicted;
		if (int'($urandom_range(99)) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= x;
		do @(posedge clk); while (!s_axis_tready);
		predicted = monitor_step(x);
		pending_reports.push_back(typed ? want : predicted);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_TRIGGER: trig_cfg = val[4:0];
			CFG_IMPROVE: imp_cfg = val;
			CFG_DEGRADE: deg_cfg = val;
			default: ;
		endcase
	endtask

	task automatic write_settings(phase_t p);
		write_reg(CFG_TRIGGER, CFG_DATA_W'(p.trigger));
		write_reg(CFG_IMPROVE, p.improve);
		write_reg(CFG_DEGRADE, p.degrade);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_idle(idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin tx_idle_pct = 0; rx_stall_pct = 0; end
			IDLE_SEND: begin tx_idle_pct = 59; rx_stall_pct = 0; end
			IDLE_RECV: begin tx_idle_pct = 0; rx_stall_pct = 59; end
			default: begin tx_idle_pct = 7; rx_stall_pct = 7; end
		endcase
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == MAX_CYCLES) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// result side: long hold-off on request, else random stalls
	initial forever begin
		@(posedge clk);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_report(m_axis_tdata);
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= (int'($urandom_range(99)) >= rx_stall_pct);
	end

	initial begin
		foreach (ring_copy[i])
			ring_copy[i] = '0;
		wr_ptr = '0;
		fill = 0;
		short_avg = '0;
		long_avg = '0;
		seeded = 1'b0;
		trig_cfg = TRIGGER_RESET;
		imp_cfg = IMPROVE_RESET;
		deg_cfg = DEGRADE_RESET;

		// reset settings: trigger 3; rising means newer > older + older/10
		directed_rows = '{
			'{16'd100,   1'b1, '{5'd0, TREND_STABLE, 1'b0}},
			'{16'd111,   1'b1, '{5'd1, TREND_STABLE, 1'b0}},
			'{16'd123,   1'b1, '{5'd2, TREND_STABLE, 1'b0}},
			'{16'd136,   1'b1, '{5'd3, TREND_STABLE, 1'b1}},
			'{16'd0,     1'b1, '{5'd0, TREND_STABLE, 1'b0}},
			'{16'd65535, 1'b1, '{5'd0, TREND_STABLE, 1'b0}},
			'{16'd65535, 1'b1, '{5'd0, TREND_STABLE, 1'b0}},
			'{16'd59577, 1'b1, '{5'd0, TREND_STABLE, 1'b0}},
			'{16'd65535, 1'b1, '{5'd1, TREND_STABLE, 1'b0}},
			'{16'd1,     1'b0, '0},
			'{16'd2,     1'b0, '0},
			'{16'd3,     1'b0, '0},
			'{16'd4,     1'b0, '0},
			'{16'd5,     1'b0, '0},
			'{16'd6,     1'b0, '0},
			'{16'd7,     1'b0, '0},
			'{16'd8,     1'b0, '0},
			'{16'd9,     1'b0, '0},
			'{16'd10,    1'b0, '0},
			'{16'd11,    1'b0, '0},
			'{16'd13,    1'b0, '0}
		};

		plan = '{
			'{5'd3,  10'd230,  10'd282,  IDLE_NONE, 1'b0},
			'{5'd1,  10'd0,    10'd0,    IDLE_SEND, 1'b0},
			'{5'd16, 10'd1023, 10'd1023, IDLE_RECV, 1'b0},
			'{5'd0,  10'd255,  10'd257,  IDLE_BOTH, 1'b0},
			'{5'd31, 10'd256,  10'd256,  IDLE_NONE, 1'b0},
			'{5'd5,  10'd200,  10'd300,  IDLE_NONE, 1'b1},
			'{5'd2,  10'd240,  10'd270,  IDLE_RECV, 1'b0},
			'{5'd3,  10'd230,  10'd282,  IDLE_BOTH, 1'b0}
		};
		plan[7].trigger = 5'($urandom_range(1, 16));
		plan[7].improve = RATIO_W'($urandom_range(180, 260));
		plan[7].degrade = RATIO_W'($urandom_range(250, 340));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idle(IDLE_NONE);
		foreach (directed_rows[i])
			send_sample(directed_rows[i].sample, directed_rows[i].typed, directed_rows[i].want);
		settle();

		foreach (plan[p]) begin
			write_settings(plan[p]);
			set_idle(plan[p].idle);
			if (plan[p].squeeze)
				rx_hold_left = HOLD_CYCLES;
			repeat (ITEMS_PER_PHASE)
				send_sample(next_rtt(), 1'b0, '0);
			settle();
		end

		if (error_count == 0 && pending_reports.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
